/* design/swm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

   localparam int SAMPLE_W        = 32;
   localparam int RESULT_W        = 33;
   localparam int CFG_W           = 7;
   localparam int DEF_MAX_WINDOW  = 64;
   localparam int RESET_WINDOW    = 3;

   // strobes from the top level into the sorted cell row
   typedef struct packed {
      logic load;    // request accepted this cycle
      logic first;   // request starts a new sequence
      logic clear;   // window size written, window empties
   } swm_ctl_type;

endpackage

`default_nettype wire

/* design/swm_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface swm_req_if
   import swm_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       first;

   modport source (output valid, output sample, output first, input ready);
   modport sink   (input valid, input sample, input first, output ready);
endinterface

`default_nettype wire

/* design/swm_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface swm_rsp_if
   import swm_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [RESULT_W-1:0] median_twice;

   modport source (output valid, output median_twice, input ready);
   modport sink   (input valid, input median_twice, output ready);
endinterface

`default_nettype wire

/* design/swm_cells.sv */
`timescale 1ns / 1ps
`default_nettype none

module swm_cells
   import swm_pkg::*;
#(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   localparam int IW = $clog2(MAX_WINDOW),
   localparam int WW = $clog2(MAX_WINDOW + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  swm_ctl_type                           ctl,
   input  logic signed [SAMPLE_W-1:0]            sample,
   input  logic        [WW-1:0]                  win,
   output logic        [MAX_WINDOW-1:0][SAMPLE_W-1:0] cell_val,
   output logic                                  done
);

   logic [MAX_WINDOW-1:0][SAMPLE_W-1:0] val_ff, val_in;
   logic [MAX_WINDOW-1:0][IW-1:0]       age_ff, age_in;
   logic [WW-1:0]                       fill_ff, fill_in;
   logic [WW-1:0]                       fill_cur, fill_next;
   logic                                full;
   logic [MAX_WINDOW-1:0]               valid, gt, del;
   logic [IW-1:0]                       oldest_age, del_idx, gap;

   assign fill_cur   = ctl.first ? '0 : fill_ff;
   assign full       = (fill_cur == win);
   assign fill_next  = full ? fill_cur : fill_cur + 1'b1;
   assign oldest_age = IW'(win - 1'b1);
   assign done       = (fill_next == win);
   assign cell_val   = val_ff;

   // per cell: occupancy, order against the new sample, oldest match
   always_comb begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
         valid[i] = (WW'(i) < fill_cur);
         gt[i]    = !valid[i] || ($signed(val_ff[i]) > sample);
         del[i]   = valid[i] && (age_ff[i] == oldest_age);
      end
   end

   always_comb begin
      del_idx = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         if (del[i]) begin
            del_idx = del_idx | IW'(i);
         end
      end
   end

   // the slot that opens: the oldest sample when full, else the first free cell
   assign gap = full ? del_idx : IW'(fill_cur);

   // each cell takes its left or right neighbor, keeps its value, or takes the sample
   always_comb begin
      for (int j = 0; j < MAX_WINDOW; j++) begin
         logic gl, gr, left, at_gap;
         int   lo, hi;
         lo     = (j == 0) ? 0 : j - 1;
         hi     = (j == MAX_WINDOW - 1) ? j : j + 1;
         gl     = (j == 0) ? 1'b0 : gt[lo];
         gr     = (j == MAX_WINDOW - 1) ? 1'b1 : gt[hi];
         left   = (IW'(j) < gap);
         at_gap = (IW'(j) == gap);
         val_in[j] = sample;
         age_in[j] = '0;
         if (left) begin
            if (gl) begin
               val_in[j] = val_ff[lo];
               age_in[j] = age_ff[lo] + 1'b1;
            end else if (!gt[j]) begin
               val_in[j] = val_ff[j];
               age_in[j] = age_ff[j] + 1'b1;
            end
         end else if (at_gap) begin
            if (!gr) begin
               val_in[j] = val_ff[hi];
               age_in[j] = age_ff[hi] + 1'b1;
            end else if (gl) begin
               val_in[j] = val_ff[lo];
               age_in[j] = age_ff[lo] + 1'b1;
            end
         end else begin
            if (!gr) begin
               val_in[j] = val_ff[hi];
               age_in[j] = age_ff[hi] + 1'b1;
            end else if (gt[j]) begin
               val_in[j] = val_ff[j];
               age_in[j] = age_ff[j] + 1'b1;
            end
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (ctl.clear) begin
         fill_in = '0;
      end else if (ctl.load) begin
         fill_in = fill_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         val_ff <= val_in;
         age_ff <= age_in;
      end
   end

endmodule

`default_nettype wire

/* design/swm_pick.sv */
`timescale 1ns / 1ps
`default_nettype none

module swm_pick
   import swm_pkg::*;
#(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   localparam int IW = $clog2(MAX_WINDOW),
   localparam int WW = $clog2(MAX_WINDOW + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [MAX_WINDOW-1:0][SAMPLE_W-1:0]   cell_val,
   input  logic [WW-1:0]                         win,
   input  logic                                  take,
   input  logic                                  out_ready,
   output logic                                  out_valid,
   output logic signed [RESULT_W-1:0]            out_data
);

   logic [IW-1:0]              lo_idx, hi_idx;
   logic [SAMPLE_W-1:0]        lo_val, hi_val;
   logic signed [RESULT_W-1:0] sum;
   logic                       valid_ff, valid_in;
   logic signed [RESULT_W-1:0] data_ff;

   // odd window: both picks land on the middle, so the sum is twice it
   assign lo_idx = IW'((win - 1'b1) >> 1);
   assign hi_idx = IW'(win >> 1);

   always_comb begin
      lo_val = '0;
      hi_val = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         lo_val = lo_val | (cell_val[i] & {SAMPLE_W{IW'(i) == lo_idx}});
         hi_val = hi_val | (cell_val[i] & {SAMPLE_W{IW'(i) == hi_idx}});
      end
   end

   assign sum = RESULT_W'($signed(lo_val)) + RESULT_W'($signed(hi_val));

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= sum;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* design/sliding_window_median.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sliding-window median of a signed 32-bit sample stream.
// req: one sample per request; first = 1 empties the window and starts a new
//   sequence with that sample. rsp: median_twice, twice the median of the last
//   window samples (sum of the two middle samples for an even window).
// No response is given until the window has filled; after that, one per request.
// csr_wr_en / csr_wr_data write the window size (0 acts as 1, values above
// MAX_WINDOW act as MAX_WINDOW) and empty the window; write only while idle.
// A result passes from the sorted cell row into the response register.
// Throughput: one request per cycle while req.ready stays high. The sorted cell
// row updates every cell in parallel, so the rate is set by the single cell
// update, not by the window size.
// Reset: window size 3, window empty, no response pending.
// Stall: the response register holds while rsp.ready is low; one more result
// can wait in the cell row, after which req.ready drops until the receiver takes.
module sliding_window_median
   import swm_pkg::*;
#(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   localparam int WW = $clog2(MAX_WINDOW + 1)
) (
   input  logic               clock,
   input  logic               reset,
   swm_req_if.sink            req,
   swm_rsp_if.source          rsp,
   input  logic               csr_wr_en,
   input  logic [CFG_W-1:0]   csr_wr_data
);

   localparam int CMP_W      = (WW > CFG_W) ? WW : CFG_W;
   localparam int RESET_WIN  = (RESET_WINDOW > MAX_WINDOW) ? MAX_WINDOW : RESET_WINDOW;

   logic [WW-1:0]                       win_ff, win_in;
   logic [CMP_W-1:0]                    raw;
   logic                                pend_ff, pend_in;
   logic                                adv, take, load, done;
   swm_ctl_type                         ctl;
   logic [MAX_WINDOW-1:0][SAMPLE_W-1:0] cell_val;

   assign raw = CMP_W'(csr_wr_data);

   always_comb begin
      win_in = win_ff;
      if (csr_wr_en) begin
         if (raw == '0) begin
            win_in = WW'(1);
         end else if (raw > CMP_W'(MAX_WINDOW)) begin
            win_in = WW'(MAX_WINDOW);
         end else begin
            win_in = WW'(raw);
         end
      end
   end

   // a finished median waits in the cell row until the response register frees
   assign adv       = !rsp.valid || rsp.ready;
   assign take      = pend_ff && adv;
   assign req.ready = !pend_ff || adv;
   assign load      = req.valid && req.ready;

   always_comb begin
      pend_in = pend_ff;
      if (load) begin
         pend_in = done;
      end else if (take) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= WW'(RESET_WIN);
         pend_ff <= 1'b0;
      end else begin
         win_ff  <= win_in;
         pend_ff <= pend_in;
      end
   end

   assign ctl.load  = load;
   assign ctl.first = req.first;
   assign ctl.clear = csr_wr_en;

   swm_cells #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_cells (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .sample   (req.sample),
      .win      (win_ff),
      .cell_val (cell_val),
      .done     (done)
   );

   swm_pick #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_pick (
      .clock     (clock),
      .reset     (reset),
      .cell_val  (cell_val),
      .win       (win_ff),
      .take      (take),
      .out_ready (rsp.ready),
      .out_valid (rsp.valid),
      .out_data  (rsp.median_twice)
   );

   // a waiting result behind a stalled response blocks new requests
   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && rsp.valid && !rsp.ready) |-> !req.ready)
      else $error("request accepted while a result could not move");

   a_take_shows: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp.valid)
      else $error("result taken from cell row but response not valid");

   a_win_range: assert property (@(posedge clock) disable iff (reset)
      (win_ff != '0) && (win_ff <= WW'(MAX_WINDOW)))
      else $error("window size out of range");

   a_load_no_stale: assert property (@(posedge clock) disable iff (reset)
      (load && pend_ff) |-> take)
      else $error("new request would overwrite a waiting result");

endmodule

`default_nettype wire

/* dv/sliding_window_median_tb.sv */
`timescale 1ns / 1ps

module sliding_window_median_tb;
   import swm_pkg::*;

   localparam int HOLD_OFF_CYCLES = 200;
   localparam int SETTLE_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT  = 4000;

   typedef enum {CHECK_MODEL, CHECK_NONE, CHECK_VALUE} check_kind_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      bit                         first;
      check_kind_type             kind;
      logic signed [RESULT_W-1:0] median_twice;
   } directed_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;

   swm_req_if req_ch ();
   swm_rsp_if rsp_ch ();

   sliding_window_median uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [CFG_W-1:0]           win_cfg = CFG_W'(RESET_WINDOW);
   int                         window_q[$];     // samples in arrival order
   logic signed [RESULT_W-1:0] median_due_q[$];

   int err_count    = 0;
   int sent_count   = 0;
   int tx_idle_pct  = 24;
   int rx_idle_pct  = 49;
   int hold_off_ask = 0;
   int hold_off_seen = 0;
   int hold_off_left = 0;
   int quiet_cycles = 0;

   directed_row_type dir_rows[$];

   function automatic void add_row(input logic signed [SAMPLE_W-1:0] s, input bit f,
                                   input check_kind_type kind,
                                   input logic signed [RESULT_W-1:0] med);
      directed_row_type row;
      row.sample       = s;
      row.first        = f;
      row.kind         = kind;
      row.median_twice = med;
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   function automatic void expect_median(input logic signed [RESULT_W-1:0] med);
      median_due_q.insert(median_due_q.size(), med);
   endfunction

   function automatic int eff_window();
      if (win_cfg == 0) return 1;
      if (win_cfg > DEF_MAX_WINDOW) return DEF_MAX_WINDOW;
      return int'(win_cfg);
   endfunction

   function automatic bit predict_median(input logic signed [SAMPLE_W-1:0] s, input bit f,
                                         output logic signed [RESULT_W-1:0] med);
      int     w;
      int     ordered[$];
      int     j;
      longint lo;
      longint hi;
      w = eff_window();
      med = '0;
      if (f) window_q.delete();
      if (window_q.size() >= w) void'(window_q.pop_front());
      window_q.insert(window_q.size(), int'(s));
      if (window_q.size() != w) return 1'b0;
      foreach (window_q[k]) begin
         j = 0;
         while (j < ordered.size() && ordered[j] <= window_q[k]) j++;
         ordered.insert(j, window_q[k]);
      end
      hi = ordered[w / 2];
      lo = (w % 2 == 1) ? hi : longint'(ordered[w / 2 - 1]);
      med = RESULT_W'(lo + hi);
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $realtime, what);
      err_count++;
   endtask

   task automatic offer_sample(input logic signed [SAMPLE_W-1:0] s, input bit f,
                               input check_kind_type kind,
                               input logic signed [RESULT_W-1:0] typed);
      logic signed [RESULT_W-1:0] med;
      bit                         has;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.sample <= s;
      req_ch.first  <= f;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      has = predict_median(s, f, med);
      case (kind)
         CHECK_MODEL: if (has) expect_median(med);
         CHECK_VALUE: expect_median(typed);
         CHECK_NONE: ;
         default: ;
      endcase
      sent_count++;
      if (sent_count == 700) begin
         tx_idle_pct = 49;
         rx_idle_pct = 24;
      end else if (sent_count == 1400) begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end
   endtask

   // the pipe may still hold requests that give no response
   task automatic settle_idle();
      req_ch.valid <= 1'b0;
      while (median_due_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [CFG_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      win_cfg = value;
      window_q.delete();
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 8) return $urandom;
      if (sel < 14) return SAMPLE_W'($signed($urandom_range(0, 8)) - 4);
      if (sel < 17) return SAMPLE_W'($signed($urandom_range(0, 2000)) - 1000);
      case ($urandom_range(0, 3))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 32'sh0;
         default: return -32'sd1;
      endcase
   endfunction

   // response side: random stalls plus one long hold-off on demand
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_ch.ready  <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else if (hold_off_seen != hold_off_ask) begin
         hold_off_seen <= hold_off_ask;
         hold_off_left <= HOLD_OFF_CYCLES;
         rsp_ch.ready  <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (median_due_q.size() == 0) begin
            report_mismatch($sformatf("unexpected response median_twice=%0d",
                                      rsp_ch.median_twice));
         end else if (rsp_ch.median_twice !== median_due_q[0]) begin
            report_mismatch($sformatf("median_twice got %0d, expected %0d",
                                      rsp_ch.median_twice, median_due_q[0]));
            void'(median_due_q.pop_front());
         end else begin
            void'(median_due_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL sliding_window_median");
            $finish;
         end
      end
   end

   initial begin
      int phase_win[13];
      int w;
      int n_items;
      logic [CFG_W-1:0] cfg;

      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.sample = '0;
      req_ch.first  = 1'b0;
      rsp_ch.ready  = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      phase_win = '{3, 0, 1, 2, 127, 64, 65, 4, 5, 7, 16, -1, -1};

      // window of 3 after reset
      add_row(32'sh0000_0000, 1'b1, CHECK_NONE,  33'h0);
      add_row(32'sh0000_0000, 1'b0, CHECK_NONE,  33'h0);
      add_row(32'sh0000_0000, 1'b0, CHECK_VALUE, 33'h0);
      add_row(32'sh7FFF_FFFF, 1'b1, CHECK_NONE,  33'h0);
      add_row(32'sh7FFF_FFFF, 1'b0, CHECK_NONE,  33'h0);
      add_row(32'sh7FFF_FFFF, 1'b0, CHECK_VALUE, 33'h0_FFFF_FFFE);
      add_row(32'sh8000_0000, 1'b1, CHECK_NONE,  33'h0);
      add_row(32'sh8000_0000, 1'b0, CHECK_NONE,  33'h0);
      add_row(32'sh8000_0000, 1'b0, CHECK_VALUE, 33'h1_0000_0000);
      add_row(32'sh7FFF_FFFF, 1'b0, CHECK_MODEL, 33'h0);
      add_row(-32'sd1,        1'b0, CHECK_MODEL, 33'h0);
      add_row(32'sd5,         1'b0, CHECK_MODEL, 33'h0);
      add_row(32'sd5,         1'b0, CHECK_MODEL, 33'h0);
      add_row(32'sd5,         1'b0, CHECK_MODEL, 33'h0);
      add_row(-32'sd7,        1'b0, CHECK_MODEL, 33'h0);
      add_row(32'sd5,         1'b0, CHECK_MODEL, 33'h0);
      // first flag on a full window
      add_row(32'sd1,         1'b1, CHECK_NONE,  33'h0);
      add_row(32'sd2,         1'b0, CHECK_NONE,  33'h0);
      add_row(32'sd3,         1'b0, CHECK_VALUE, 33'h0_0000_0004);
      add_row(32'sh5555_5555, 1'b0, CHECK_MODEL, 33'h0);
      add_row(32'shAAAA_AAAA, 1'b0, CHECK_MODEL, 33'h0);
      // leave the window partly filled; the next size write must empty it
      add_row(32'sd9,         1'b1, CHECK_NONE,  33'h0);
      add_row(32'sd9,         1'b0, CHECK_NONE,  33'h0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         offer_sample(dir_rows[i].sample, dir_rows[i].first, dir_rows[i].kind,
                      dir_rows[i].median_twice);
      settle_idle();

      foreach (phase_win[p]) begin
         cfg = (phase_win[p] < 0) ? CFG_W'($urandom_range(1, 127)) : CFG_W'(phase_win[p]);
         write_window(cfg);
         w = eff_window();
         // receiver holds off while requests keep coming, so the input backs up
         if (p == 3) hold_off_ask++;
         n_items = 120 + 2 * w;
         for (int k = 0; k < n_items; k++)
            offer_sample(pick_sample(), ($urandom_range(0, 4 * w + 8) == 0),
                         CHECK_MODEL, '0);
         settle_idle();
      end

      if (err_count == 0) begin
         $display("PASS sliding_window_median");
      end else begin
         $display("FAIL sliding_window_median");
      end
      $finish;
   end

endmodule
